### rtl/opsa_pkg.sv
// ----------------------------------------------------------------------------
// Object pool slot allocator package
// Item types, status and request codes, register indexes and fixed limits
// used by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package opsa_pkg;

  // Fixed field widths.
  localparam int RowW    = 4;
  localparam int ColW    = 8;
  localparam int BumpW   = 9;
  localparam int OffW    = 20;
  localparam int SpcW    = 9;
  localparam int BytesW  = 13;
  localparam int EntryW  = RowW + ColW;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 13;

  // Pool geometry limits.
  localparam int MaxRows    = 16;
  localparam int MaxChunk   = 256;
  localparam int RowLimit   = 16;
  localparam int ColLimit   = 256;
  localparam int BytesLimit = 4096;

  // Number of rows the bump pointer may use, at least one.
  localparam int RowCount  = (MaxRows > RowLimit) ? RowLimit : ((MaxRows < 1) ? 1 : MaxRows);
  // Largest usable chunk size.
  localparam int ChunkCap  = (MaxChunk < ColLimit) ? MaxChunk : ColLimit;

  // Reset values of the configuration registers.
  localparam logic [SpcW-1:0]   SpcReset   = SpcW'(64);
  localparam logic [BytesW-1:0] BytesReset = BytesW'(16);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_PER_CHUNK = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_OBJECT_BYTES    = 1'b1;

  // Request codes.
  localparam logic REQ_GET    = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE    = 2'd1;
  localparam logic [1:0] STATUS_STACK_FULL  = 2'd2;

  typedef struct packed {
    logic            req_type;
    logic [RowW-1:0] free_row;
    logic [ColW-1:0] free_column;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0] slot_row;
    logic [ColW-1:0] slot_column;
    logic [OffW-1:0] byte_offset;
    logic            reused;
    logic [1:0]      status;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/opsa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module opsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/object_pool_slot_allocator.sv
// ----------------------------------------------------------------------------
// Object pool slot allocator
// Hands out fixed-size object slots from a LIFO free stack or a bump pointer
// over chunk rows, and takes returned slots back onto the stack.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle and busy never rises, so a
// client may issue requests back to back. Each request gives exactly one
// result, shown for one cycle with out_strobe high; results leave in request
// order. A result passes from the first-stage registers, alongside the free
// stack memory's registered read data, through the column-times-size
// multiplier into the output register. The receiver cannot stall, so
// out_strobe is never held. The free stack needs no clearing after reset:
// only entries below the fill count are ever read. Configuration writes are
// taken at once and should be made while no request is in flight.
`default_nettype none

module object_pool_slot_allocator #(
  parameter int FREE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire opsa_pkg::in_item_t            in_item,
  // Result channel.
  output logic                               out_strobe,
  output opsa_pkg::out_item_t                out_item,
  // Configuration port.
  input  wire logic                          cfg_we,
  input  wire logic [opsa_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [opsa_pkg::CfgW-1:0]     cfg_wdata
);

  localparam int AddrW  = $clog2(FREE_DEPTH);
  localparam int CountW = $clog2(FREE_DEPTH + 1);

  // Configuration registers.
  logic [opsa_pkg::SpcW-1:0]   spc_r;
  logic [opsa_pkg::BytesW-1:0] bytes_r;

  // Allocator state.
  logic [CountW-1:0]          free_count_r, free_count_nxt;
  logic [opsa_pkg::RowW-1:0]  bump_row_r, bump_row_nxt;
  logic [opsa_pkg::BumpW-1:0] bump_col_r, bump_col_nxt;

  // First stage: decision taken at the accepting edge.
  logic                       s1_valid_r;
  logic                       s1_reused_r, s1_reused_nxt;
  logic [opsa_pkg::RowW-1:0]  s1_row_r, s1_row_nxt;
  logic [opsa_pkg::ColW-1:0]  s1_col_r, s1_col_nxt;
  logic [1:0]                 s1_status_r, s1_status_nxt;

  // Result register.
  logic                       out_strobe_r;
  opsa_pkg::out_item_t        out_item_r, out_item_nxt;

  // Free stack memory.
  logic                         ram_we, ram_re;
  logic [AddrW-1:0]             ram_waddr, ram_raddr;
  logic [opsa_pkg::EntryW-1:0]  ram_wdata, ram_rdata;

  logic                         accept;
  logic [opsa_pkg::SpcW-1:0]    chunk_size;
  logic [opsa_pkg::BytesW-1:0]  bytes_eff;
  logic [CountW-1:0]            count_dec;
  logic [opsa_pkg::RowW:0]      row_inc;
  logic [opsa_pkg::ColW-1:0]    res_col;
  logic [opsa_pkg::ColW+opsa_pkg::BytesW-1:0] offset_full;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // A chunk size of zero acts as one; larger values are capped.
  always_comb begin
    if (spc_r == '0) begin
      chunk_size = opsa_pkg::SpcW'(1);
    end else if (spc_r > opsa_pkg::SpcW'(opsa_pkg::ChunkCap)) begin
      chunk_size = opsa_pkg::SpcW'(opsa_pkg::ChunkCap);
    end else begin
      chunk_size = spc_r;
    end
  end

  assign bytes_eff = (bytes_r > opsa_pkg::BytesW'(opsa_pkg::BytesLimit)) ?
                     opsa_pkg::BytesW'(opsa_pkg::BytesLimit) : bytes_r;

  assign count_dec = free_count_r - CountW'(1);
  assign row_inc   = {1'b0, bump_row_r} + (opsa_pkg::RowW+1)'(1);

  // Request decision: pop, bump or push, all against the current state.
  always_comb begin
    free_count_nxt = free_count_r;
    bump_row_nxt   = bump_row_r;
    bump_col_nxt   = bump_col_r;
    s1_reused_nxt  = 1'b0;
    s1_row_nxt     = '0;
    s1_col_nxt     = '0;
    s1_status_nxt  = opsa_pkg::STATUS_OK;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = free_count_r[AddrW-1:0];
    ram_raddr      = count_dec[AddrW-1:0];
    ram_wdata      = {in_item.free_row, in_item.free_column};

    if (accept) begin
      unique case (in_item.req_type)
        opsa_pkg::REQ_GET: begin
          if (free_count_r != '0) begin
            // Most recently returned slot; its fields arrive from memory
            // in the next cycle.
            ram_re         = 1'b1;
            free_count_nxt = count_dec;
            s1_reused_nxt  = 1'b1;
          end else if (bump_col_r >= chunk_size) begin
            // Current row is full: move on to the next one if there is one.
            if (row_inc >= (opsa_pkg::RowW+1)'(opsa_pkg::RowCount)) begin
              s1_status_nxt = opsa_pkg::STATUS_NO_SPACE;
            end else begin
              bump_row_nxt = row_inc[opsa_pkg::RowW-1:0];
              bump_col_nxt = opsa_pkg::BumpW'(1);
              s1_row_nxt   = row_inc[opsa_pkg::RowW-1:0];
              s1_col_nxt   = '0;
            end
          end else begin
            s1_row_nxt   = bump_row_r;
            s1_col_nxt   = bump_col_r[opsa_pkg::ColW-1:0];
            bump_col_nxt = bump_col_r + opsa_pkg::BumpW'(1);
          end
        end
        opsa_pkg::REQ_DELETE: begin
          if (free_count_r == CountW'(FREE_DEPTH)) begin
            s1_status_nxt = opsa_pkg::STATUS_STACK_FULL;
          end else begin
            ram_we         = 1'b1;
            free_count_nxt = free_count_r + CountW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Second stage: pick the slot fields and scale the column to bytes.
  assign res_col     = s1_reused_r ? ram_rdata[opsa_pkg::ColW-1:0] : s1_col_r;
  assign offset_full = res_col * bytes_eff;

  always_comb begin
    out_item_nxt.slot_row    = s1_reused_r ? ram_rdata[opsa_pkg::EntryW-1:opsa_pkg::ColW]
                                           : s1_row_r;
    out_item_nxt.slot_column = res_col;
    out_item_nxt.byte_offset = offset_full[opsa_pkg::OffW-1:0];
    out_item_nxt.reused      = s1_reused_r;
    out_item_nxt.status      = s1_status_r;
  end

  opsa_ram #(
    .WIDTH (opsa_pkg::EntryW),
    .DEPTH (FREE_DEPTH)
  ) u_free_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r        <= opsa_pkg::SpcReset;
      bytes_r      <= opsa_pkg::BytesReset;
      free_count_r <= '0;
      bump_row_r   <= '0;
      bump_col_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          opsa_pkg::CFG_SLOTS_PER_CHUNK: spc_r   <= cfg_wdata[opsa_pkg::SpcW-1:0];
          opsa_pkg::CFG_OBJECT_BYTES:    bytes_r <= cfg_wdata[opsa_pkg::BytesW-1:0];
          default: begin
          end
        endcase
      end
      free_count_r <= free_count_nxt;
      bump_row_r   <= bump_row_nxt;
      bump_col_r   <= bump_col_nxt;
      s1_valid_r   <= accept;
      out_strobe_r <= s1_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_reused_r <= s1_reused_nxt;
    s1_row_r    <= s1_row_nxt;
    s1_col_r    <= s1_col_nxt;
    s1_status_r <= s1_status_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire
